// ----- sv/stcm_pkg.sv -----
// Shared constants and types for the speed-to-color map unit.
// No dependencies; used by every module of the block.
package stcm_pkg;

    // Width of one coordinate field
    localparam int IN_W = 24;

    // Width and fraction bits of one color intensity
    localparam int OUT_W    = 13;
    localparam int OUT_FRAC = 12;

    // Queue status seen by both sides of the decoupling queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- sv/stcm_queue.sv -----
// Short FIFO that decouples the front (distance) and back (root, color) sections.
// Depends on stcm_pkg for the status struct.
module stcm_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_W-1:0]    wr_data,
    input  logic                 pop,
    output logic [DATA_W-1:0]    rd_data,
    output stcm_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);

endmodule

// ----- sv/stcm_front.sv -----
// Front section: accepts point pairs, forms axis differences, flags large steps,
// squares and sums the magnitudes. Depends on stcm_pkg.
module stcm_front #(
    parameter int FRAC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [stcm_pkg::IN_W-1:0]  cur_x,
    input  logic signed [stcm_pkg::IN_W-1:0]  cur_y,
    input  logic signed [stcm_pkg::IN_W-1:0]  cur_z,
    input  logic signed [stcm_pkg::IN_W-1:0]  prev_x,
    input  logic signed [stcm_pkg::IN_W-1:0]  prev_y,
    input  logic signed [stcm_pkg::IN_W-1:0]  prev_z,
    input  stcm_pkg::q_status_t               q_status,
    output logic                              push,
    output logic [2*FRAC_BITS+8:0]            push_data
);

    localparam int DIFF_W = stcm_pkg::IN_W + 1;
    localparam int MAG_W  = FRAC_BITS + 3;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam logic signed [DIFF_W-1:0] BIG_POS = DIFF_W'(5 << FRAC_BITS);
    localparam logic signed [DIFF_W-1:0] BIG_NEG = -BIG_POS;

    logic                       front_en;
    logic signed [stcm_pkg::IN_W-1:0] cur  [3];
    logic signed [stcm_pkg::IN_W-1:0] prev [3];

    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DIFF_W-1:0]   diff_reg [3];
    logic signed [DIFF_W-1:0]   diff_next [3];
    logic [MAG_W-1:0]           mag_reg [3];
    logic [MAG_W-1:0]           mag_next [3];
    logic [SQ_W-1:0]            sq_reg [3];
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic                       big2_reg, big3_reg, big4_reg, big2_next;
    logic [DIFF_W-1:0]          abs_full;

    assign cur[0]  = cur_x;
    assign cur[1]  = cur_y;
    assign cur[2]  = cur_z;
    assign prev[0] = prev_x;
    assign prev[1] = prev_y;
    assign prev[2] = prev_z;

    // The section advances unless its last stage is blocked by a full queue
    assign front_en = !(v4_reg && q_status.full);
    assign in_stall = !front_en;

    // Stage 1: signed differences
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_next[i] = DIFF_W'(cur[i]) - DIFF_W'(prev[i]);
        end
    end

    // Stage 2: magnitudes and large-step flag
    always_comb
    begin
        big2_next = 1'b0;
        abs_full  = '0;
        for (int i = 0; i < 3; i++)
        begin
            abs_full    = diff_reg[i][DIFF_W-1] ? -diff_reg[i] : diff_reg[i];
            mag_next[i] = abs_full[MAG_W-1:0];
            if ((diff_reg[i] >= BIG_POS) || (diff_reg[i] <= BIG_NEG))
            begin
                big2_next = 1'b1;
            end
        end
    end

    // Stage 4 input: sum of squares
    assign sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (front_en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= diff_next[i];
                mag_reg[i]  <= mag_next[i];
                sq_reg[i]   <= mag_reg[i] * mag_reg[i];
            end
            big2_reg <= big2_next;
            big3_reg <= big2_reg;
            big4_reg <= big3_reg;
            sum_reg  <= sum_next;
        end
    end

    assign push      = v4_reg && front_en;
    assign push_data = {big4_reg, sum_reg};

endmodule

// ----- sv/stcm_back.sv -----
// Back section: pipelined integer square root, one root bit per stage, then the
// six-band color map and the output register. Depends on stcm_pkg.
module stcm_back #(
    parameter int FRAC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  stcm_pkg::q_status_t               q_status,
    input  logic [2*FRAC_BITS+8:0]            q_data,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stcm_pkg::OUT_W-1:0]        red,
    output logic [stcm_pkg::OUT_W-1:0]        green,
    output logic [stcm_pkg::OUT_W-1:0]        blue
);

    localparam int R_W   = FRAC_BITS + 4;
    localparam int SUM_W = 2 * R_W;
    localparam int C_W   = FRAC_BITS + 1;
    localparam int CV_W  = C_W + stcm_pkg::OUT_FRAC;
    localparam int SHR   = (FRAC_BITS >= stcm_pkg::OUT_FRAC) ?
                           FRAC_BITS - stcm_pkg::OUT_FRAC : 0;
    localparam int SHL   = (FRAC_BITS < stcm_pkg::OUT_FRAC) ?
                           stcm_pkg::OUT_FRAC - FRAC_BITS : 0;

    localparam logic [R_W-1:0] ONE_V   = R_W'(1 << FRAC_BITS);
    localparam logic [R_W-1:0] TWO_V   = R_W'(2 << FRAC_BITS);
    localparam logic [R_W-1:0] THREE_V = R_W'(3 << FRAC_BITS);
    localparam logic [R_W-1:0] FOUR_V  = R_W'(4 << FRAC_BITS);
    localparam logic [R_W-1:0] FIVE_V  = R_W'(5 << FRAC_BITS);
    localparam logic [C_W-1:0] ONE_C   = C_W'(1 << FRAC_BITS);

    logic                 back_en;
    logic                 vld_reg [R_W];
    logic [R_W-1:0]       q_reg   [R_W];
    logic                 big_reg [R_W];
    logic [SUM_W-1:0]     rem_reg [R_W-1];

    logic [R_W-1:0]       root;
    logic [C_W-1:0]       r_c, g_c, b_c;
    logic                 out_valid_reg;
    logic [stcm_pkg::OUT_W-1:0] red_reg, green_reg, blue_reg;

    // Convert a band value to Q1.12
    function automatic logic [stcm_pkg::OUT_W-1:0] to_out(input logic [C_W-1:0] x);
        logic [CV_W-1:0] t;
        t = CV_W'(x);
        t = (t >> SHR) << SHL;
        return t[stcm_pkg::OUT_W-1:0];
    endfunction

    // The whole section moves unless a finished transaction waits at the output
    assign back_en = !(out_valid_reg && out_stall);
    assign pop     = back_en && !q_status.empty;

    // Root pipeline: stage s decides root bit R_W-1-s
    for (genvar s = 0; s < R_W; s++)
    begin : g_root
        localparam int K = R_W - 1 - s;

        logic [SUM_W-1:0] rem_in, trial, rem_next;
        logic [R_W-1:0]   q_in, q_next;
        logic             big_in, vld_in, fits;

        if (s == 0)
        begin : g_head
            assign rem_in = q_data[SUM_W-1:0];
            assign q_in   = '0;
            assign big_in = q_data[SUM_W];
            assign vld_in = pop;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign big_in = big_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        // (q + 2^K)^2 - q^2 = q*2^(K+1) + 2^(2K)
        assign trial    = (SUM_W'(q_in) << (K + 1)) | (SUM_W'(1) << (2 * K));
        assign fits     = (rem_in >= trial);
        assign rem_next = fits ? rem_in - trial : rem_in;
        assign q_next   = fits ? (q_in | (R_W'(1) << K)) : q_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (back_en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (back_en)
            begin
                q_reg[s]   <= q_next;
                big_reg[s] <= big_in;
            end
        end

        if (s < R_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (back_en)
                begin
                    rem_reg[s] <= rem_next;
                end
            end
        end
    end

    assign root = q_reg[R_W-1];

    // Six-band color map; a large axis step forces magenta
    always_comb
    begin
        r_c = ONE_C;
        g_c = '0;
        b_c = ONE_C;
        priority if (big_reg[R_W-1])
        begin
            r_c = ONE_C;
            g_c = '0;
            b_c = ONE_C;
        end
        else if (root < ONE_V)
        begin
            r_c = '0;
            g_c = C_W'(root);
            b_c = ONE_C;
        end
        else if (root < TWO_V)
        begin
            r_c = '0;
            g_c = ONE_C;
            b_c = C_W'(TWO_V - root);
        end
        else if (root < THREE_V)
        begin
            r_c = C_W'(root - TWO_V);
            g_c = ONE_C;
            b_c = '0;
        end
        else if (root < FOUR_V)
        begin
            r_c = ONE_C;
            g_c = C_W'(FOUR_V - root);
            b_c = '0;
        end
        else if (root < FIVE_V)
        begin
            r_c = ONE_C;
            g_c = '0;
            b_c = C_W'(root - FOUR_V);
        end
        else
        begin
            r_c = ONE_C;
            g_c = '0;
            b_c = ONE_C;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            out_valid_reg <= vld_reg[R_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            red_reg   <= to_out(r_c);
            green_reg <= to_out(g_c);
            blue_reg  <= to_out(b_c);
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ----- sv/speed_to_color_map_unit.sv -----
// Speed-to-color map, top level: front section, decoupling queue, back section.
// Depends on stcm_pkg, stcm_front, stcm_queue and stcm_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per point pair:
//   cur_x/y/z and prev_x/y/z, signed fixed point with FRAC_BITS fraction bits.
//   Output channel (out_valid / out_stall) returns one transaction per input:
//   red, green, blue as unsigned Q1.12 (4096 is full intensity).
//   A transaction moves at a rising edge with valid high and stall low.
// Pipeline: four front stages, the queue storage register, one square-root
//   stage per result bit (FRAC_BITS + 4 of them) and the output register.
// Throughput: one transaction per cycle while out_stall is low; every stage
//   is pipelined.
// Stall: when out_stall holds a result, the back section freezes, the queue
//   fills, and in_stall rises once the queue is full while the last front
//   stage holds a transaction; the whole front section then waits.
// Reset: rst_n clears all valid bits, queue pointers and the fill count; no
//   transaction is in flight afterward. Payload registers are not reset.
module speed_to_color_map_unit #(
    parameter int FRAC_BITS   = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [stcm_pkg::IN_W-1:0]  cur_x,
    input  logic signed [stcm_pkg::IN_W-1:0]  cur_y,
    input  logic signed [stcm_pkg::IN_W-1:0]  cur_z,
    input  logic signed [stcm_pkg::IN_W-1:0]  prev_x,
    input  logic signed [stcm_pkg::IN_W-1:0]  prev_y,
    input  logic signed [stcm_pkg::IN_W-1:0]  prev_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stcm_pkg::OUT_W-1:0]        red,
    output logic [stcm_pkg::OUT_W-1:0]        green,
    output logic [stcm_pkg::OUT_W-1:0]        blue
);

    // Queue entry: large-step flag over the sum of squares
    localparam int ENTRY_W = 2 * FRAC_BITS + 9;

    stcm_pkg::q_status_t   q_status;
    logic                  push, pop;
    logic [ENTRY_W-1:0]    push_data, q_data;

    stcm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cur_x     (cur_x),
        .cur_y     (cur_y),
        .cur_z     (cur_z),
        .prev_x    (prev_x),
        .prev_y    (prev_y),
        .prev_z    (prev_z),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    stcm_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .pop     (pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    stcm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule
